>>> src/cascaded_pd_balance_controller_assert.svh
// assertion helpers for the balance controller checker
`ifndef CASCADED_PD_BALANCE_CONTROLLER_ASSERT_SVH
`define CASCADED_PD_BALANCE_CONTROLLER_ASSERT_SVH

// consequent checked in the same cycle
`define CPBC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the following cycle
`define CPBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/cpbc_pkg.sv
package cpbc_pkg;

	localparam int POS_W      = 32;
	localparam int PITCH_W    = 19;
	localparam int GAIN_W     = 24;
	localparam int ERR_W      = 32;
	localparam int VEL_W      = 33;
	localparam int DIFF_W     = 33;
	localparam int SUM_W      = 34;
	localparam int PDEG_W     = 26;
	localparam int TORQUE_W   = 32;
	localparam int VSP_OUT_W  = 15;
	localparam int ASP_OUT_W  = 21;
	localparam int REG_IDX_W  = 3;
	localparam int REG_DATA_W = 32;

	// serial multiplier operand widths
	localparam int MAC_XW = 39;
	localparam int MAC_YW = GAIN_W;
	localparam int PROD_W = MAC_XW + MAC_YW + 2;

	// 180 / 3.141593 scaled by 2^32
	localparam logic signed [MAC_XW-1:0] DEG_PER_RAD_Q32 = 39'sd246083473680;
	localparam int DEG_SHIFT = 32;

	localparam logic [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

	typedef enum logic [REG_IDX_W-1:0] {
		REG_POSITION_TARGET = 3'd0,
		REG_POSITION_P_GAIN = 3'd1,
		REG_POSITION_D_GAIN = 3'd2,
		REG_VELOCITY_P_GAIN = 3'd3,
		REG_VELOCITY_D_GAIN = 3'd4,
		REG_ANGLE_P_GAIN    = 3'd5,
		REG_ANGLE_D_GAIN    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0]  position_target;
		logic [GAIN_W-1:0] position_p_gain;
		logic [GAIN_W-1:0] position_d_gain;
		logic [GAIN_W-1:0] velocity_p_gain;
		logic [GAIN_W-1:0] velocity_d_gain;
		logic [GAIN_W-1:0] angle_p_gain;
		logic [GAIN_W-1:0] angle_d_gain;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		position_target: 32'd2621440,
		position_p_gain: 24'd1311,
		position_d_gain: 24'd6554,
		velocity_p_gain: 24'd4063232,
		velocity_d_gain: 24'd0,
		angle_p_gain:    24'd524,
		angle_d_gain:    24'd5243
	};

endpackage

>>> src/cpbc_if.sv
interface cpbc_meas_if;
	import cpbc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [POS_W-1:0]   left_wheel_pos;
	logic signed [POS_W-1:0]   right_wheel_pos;
	logic signed [PITCH_W-1:0] body_pitch;

	modport source(output valid, output left_wheel_pos, output right_wheel_pos,
		output body_pitch, input ready);
	modport sink(input valid, input left_wheel_pos, input right_wheel_pos,
		input body_pitch, output ready);
endinterface

interface cpbc_cmd_if;
	import cpbc_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [TORQUE_W-1:0]  drive_torque;
	logic signed [VSP_OUT_W-1:0] velocity_setpoint;
	logic signed [ASP_OUT_W-1:0] angle_setpoint;

	modport source(output valid, output drive_torque, output velocity_setpoint,
		output angle_setpoint, input ready);
	modport sink(input valid, input drive_torque, input velocity_setpoint,
		input angle_setpoint, output ready);
endinterface

>>> src/cpbc_serial_mac.sv
module cpbc_serial_mac #(
	parameter int XW = 39,
	parameter int YW = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [XW-1:0]    x1,
	input  logic signed [XW-1:0]    x2,
	input  logic [YW-1:0]           y1,
	input  logic [YW-1:0]           y2,
	output logic                    done,
	output logic signed [XW+YW+1:0] prod
);
	localparam int AW = XW + 2;
	localparam int CW = $clog2(YW);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic signed [AW-1:0] acc_hi_q;
	logic [YW-1:0]        acc_lo_q;
	logic signed [XW-1:0] x1_q;
	logic signed [XW-1:0] x2_q;
	logic [YW-1:0]        y1_q;
	logic [YW-1:0]        y2_q;

	logic                 last;
	logic signed [AW-1:0] pp;
	logic signed [AW-1:0] sum;

	assign last = (cnt_q == CW'(YW - 1));

	always_comb begin
		pp = '0;
		if (y1_q[0]) begin
			pp = pp + AW'(x1_q);
		end
		if (y2_q[0]) begin
			pp = pp + AW'(x2_q);
		end
		// multiplier sign bit carries negative weight
		sum = last ? (acc_hi_q - pp) : (acc_hi_q + pp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			x1_q     <= x1;
			x2_q     <= x2;
			y1_q     <= y1;
			y2_q     <= y2;
			acc_hi_q <= '0;
		end else if (busy_q) begin
			acc_hi_q <= sum >>> 1;
			acc_lo_q <= {sum[0], acc_lo_q[YW-1:1]};
			y1_q     <= y1_q >> 1;
			y2_q     <= y2_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = {acc_hi_q, acc_lo_q};

endmodule

>>> src/cpbc_regs.sv
module cpbc_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [cpbc_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [cpbc_pkg::REG_DATA_W-1:0] wr_data,
	output cpbc_pkg::cfg_t                  cfg
);
	import cpbc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_POSITION_TARGET: cfg_q.position_target <= wr_data[POS_W-1:0];
				REG_POSITION_P_GAIN: cfg_q.position_p_gain <= wr_data[GAIN_W-1:0];
				REG_POSITION_D_GAIN: cfg_q.position_d_gain <= wr_data[GAIN_W-1:0];
				REG_VELOCITY_P_GAIN: cfg_q.velocity_p_gain <= wr_data[GAIN_W-1:0];
				REG_VELOCITY_D_GAIN: cfg_q.velocity_d_gain <= wr_data[GAIN_W-1:0];
				REG_ANGLE_P_GAIN:    cfg_q.angle_p_gain    <= wr_data[GAIN_W-1:0];
				REG_ANGLE_D_GAIN:    cfg_q.angle_d_gain    <= wr_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/cascaded_pd_balance_controller.sv
// Cascaded PD balance controller, one control tick per measurement beat.
// meas: L/R wheel encoder angle (Q16.16), body pitch (Q3.16), in radians.
// cmd: drive torque, velocity setpoint and angle setpoint for that tick.
// wr_en/wr_index/wr_data: target and gain registers, to be written by the
//   user only while idle (unchecked by the block); an index past the last
//   register is dropped.
// Each tick runs four passes through one bit-serial multiplier (pitch to
//   degrees, then the position, velocity and angle loops) plus nine steps
//   for the multiplier starts, error sums, clamps and the output load, and
//   the idle state in which the next beat is taken.
// meas.ready is high only while no tick is being worked on.
// cmd is a single output register: a new tick may start while the previous
//   result waits, and a finished tick holds in its last step until the
//   receiver drains the register.
// Reset: registers return to their defaults, previous wheel positions and
//   previous loop errors clear to zero, cmd.valid drops.
module cascaded_pd_balance_controller #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	cpbc_meas_if.sink                       meas,
	cpbc_cmd_if.source                      cmd,
	input  logic                            wr_en,
	input  logic [cpbc_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [cpbc_pkg::REG_DATA_W-1:0] wr_data
);
	import cpbc_pkg::*;

	localparam int VEL_LIMIT = ((1 << FRAC_BITS) * 2 + 5) / 10;
	localparam int ANG_LIMIT = 10 << FRAC_BITS;
	localparam int VSP_W     = $clog2(VEL_LIMIT + 1) + 1;
	localparam int ASP_W     = $clog2(ANG_LIMIT + 1) + 1;
	localparam int RND_W     = PROD_W - FRAC_BITS;

	localparam logic signed [RND_W-1:0] VEL_HI = RND_W'(VEL_LIMIT);
	localparam logic signed [RND_W-1:0] VEL_LO = -VEL_HI;
	localparam logic signed [RND_W-1:0] ANG_HI = RND_W'(ANG_LIMIT);
	localparam logic signed [RND_W-1:0] ANG_LO = -ANG_HI;

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_PERR   = 14'b00000000000010,
		ST_WPITCH = 14'b00000000000100,
		ST_LPOS   = 14'b00000000001000,
		ST_WPOS   = 14'b00000000010000,
		ST_CVSP   = 14'b00000000100000,
		ST_VERR   = 14'b00000001000000,
		ST_LVEL   = 14'b00000010000000,
		ST_WVEL   = 14'b00000100000000,
		ST_CASP   = 14'b00001000000000,
		ST_AERR   = 14'b00010000000000,
		ST_LANG   = 14'b00100000000000,
		ST_WANG   = 14'b01000000000000,
		ST_OUT    = 14'b10000000000000
	} state_t;

	function automatic logic signed [ERR_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
		logic all_ones;
		logic any_one;
		all_ones = &v[SUM_W-1:ERR_W-1];
		any_one  = |v[SUM_W-1:ERR_W-1];
		if (all_ones || !any_one) begin
			return v[ERR_W-1:0];
		end else if (v[SUM_W-1]) begin
			return ERR_MIN;
		end else begin
			return ERR_MAX;
		end
	endfunction

	function automatic logic signed [ERR_W-1:0] sat_rnd(input logic signed [RND_W-1:0] v);
		logic all_ones;
		logic any_one;
		all_ones = &v[RND_W-1:ERR_W-1];
		any_one  = |v[RND_W-1:ERR_W-1];
		if (all_ones || !any_one) begin
			return v[ERR_W-1:0];
		end else if (v[RND_W-1]) begin
			return ERR_MIN;
		end else begin
			return ERR_MAX;
		end
	endfunction

	cfg_t cfg;

	state_t state_q;

	logic signed [POS_W-1:0]     prev_left_q;
	logic signed [POS_W-1:0]     prev_right_q;
	logic signed [ERR_W-1:0]     prev_perr_q;
	logic signed [ERR_W-1:0]     prev_verr_q;
	logic signed [ERR_W-1:0]     prev_aerr_q;

	logic signed [POS_W-1:0]     pos_q;
	logic signed [VEL_W-1:0]     vel_q;
	logic signed [PITCH_W-1:0]   pitch_q;
	logic signed [PDEG_W-1:0]    pdeg_q;
	logic signed [ERR_W-1:0]     perr_q;
	logic signed [ERR_W-1:0]     verr_q;
	logic signed [ERR_W-1:0]     aerr_q;
	logic signed [RND_W-1:0]     rnd_q;
	logic signed [VSP_W-1:0]     vsp_q;
	logic signed [ASP_W-1:0]     asp_q;

	logic                        cmd_valid_q;
	logic signed [TORQUE_W-1:0]  torque_q;
	logic signed [VSP_OUT_W-1:0] vsp_out_q;
	logic signed [ASP_OUT_W-1:0] asp_out_q;

	logic                        accept;
	logic                        out_load;
	logic signed [POS_W:0]       pos_sum;
	logic signed [SUM_W-1:0]     vel_sum;
	logic signed [SUM_W-1:0]     perr_sum;
	logic signed [SUM_W-1:0]     verr_sum;
	logic signed [SUM_W-1:0]     aerr_sum;

	logic                        mac_start;
	logic signed [MAC_XW-1:0]    mac_x1;
	logic signed [MAC_XW-1:0]    mac_x2;
	logic [MAC_YW-1:0]           mac_y1;
	logic [MAC_YW-1:0]           mac_y2;
	logic                        mac_done;
	logic signed [PROD_W-1:0]    mac_prod;
	logic signed [ERR_W-1:0]     sel_err;
	logic signed [ERR_W-1:0]     sel_prev;
	logic signed [DIFF_W-1:0]    err_diff;

	logic signed [PROD_W-1:0]    prod_frac_sh;
	logic signed [PROD_W-1:0]    prod_deg_sh;
	logic signed [RND_W-1:0]     rnd_next;
	logic signed [PDEG_W-1:0]    pdeg_next;
	logic signed [VSP_W-1:0]     vsp_next;
	logic signed [ASP_W-1:0]     asp_next;

	cpbc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	cpbc_serial_mac #(
		.XW (MAC_XW),
		.YW (MAC_YW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.x1     (mac_x1),
		.x2     (mac_x2),
		.y1     (mac_y1),
		.y2     (mac_y2),
		.done   (mac_done),
		.prod   (mac_prod)
	);

	assign meas.ready = (state_q == ST_IDLE);
	assign accept     = meas.valid && meas.ready;
	assign out_load   = (state_q == ST_OUT) && (!cmd_valid_q || cmd.ready);

	// wheel mean and mean change, both floored
	assign pos_sum  = (POS_W+1)'(meas.left_wheel_pos) + (POS_W+1)'(meas.right_wheel_pos);
	assign vel_sum  = SUM_W'(meas.left_wheel_pos) - SUM_W'(prev_left_q)
		+ SUM_W'(meas.right_wheel_pos) - SUM_W'(prev_right_q);
	assign perr_sum = SUM_W'($signed(cfg.position_target)) + SUM_W'(pos_q);
	assign verr_sum = SUM_W'(vsp_q) + SUM_W'(vel_q);
	assign aerr_sum = SUM_W'(asp_q) + SUM_W'(pdeg_q);

	// operand select for the shared multiplier
	always_comb begin
		sel_err   = '0;
		sel_prev  = '0;
		mac_y1    = '0;
		mac_y2    = '0;
		mac_start = 1'b0;
		unique case (state_q)
			ST_PERR: begin
				mac_start = 1'b1;
				mac_y1    = MAC_YW'(pitch_q);
			end
			ST_LPOS: begin
				mac_start = 1'b1;
				sel_err   = perr_q;
				sel_prev  = prev_perr_q;
				mac_y1    = cfg.position_p_gain;
				mac_y2    = cfg.position_d_gain;
			end
			ST_LVEL: begin
				mac_start = 1'b1;
				sel_err   = verr_q;
				sel_prev  = prev_verr_q;
				mac_y1    = cfg.velocity_p_gain;
				mac_y2    = cfg.velocity_d_gain;
			end
			ST_LANG: begin
				mac_start = 1'b1;
				sel_err   = aerr_q;
				sel_prev  = prev_aerr_q;
				mac_y1    = cfg.angle_p_gain;
				mac_y2    = cfg.angle_d_gain;
			end
			default: ;
		endcase
		err_diff = DIFF_W'(sel_err) - DIFF_W'(sel_prev);
		mac_x1   = (state_q == ST_PERR) ? DEG_PER_RAD_Q32 : MAC_XW'(sel_err);
		mac_x2   = MAC_XW'(err_diff);
	end

	// round half up: floor of the shift plus the first dropped bit
	always_comb begin
		prod_frac_sh = mac_prod >>> FRAC_BITS;
		prod_deg_sh  = mac_prod >>> DEG_SHIFT;
		rnd_next     = prod_frac_sh[RND_W-1:0] + RND_W'(mac_prod[FRAC_BITS-1]);
		pdeg_next    = prod_deg_sh[PDEG_W-1:0] + PDEG_W'(mac_prod[DEG_SHIFT-1]);

		if (rnd_q > VEL_HI) begin
			vsp_next = VSP_W'(VEL_HI);
		end else if (rnd_q < VEL_LO) begin
			vsp_next = VSP_W'(VEL_LO);
		end else begin
			vsp_next = VSP_W'(rnd_q);
		end

		if (rnd_q > ANG_HI) begin
			asp_next = ASP_W'(ANG_HI);
		end else if (rnd_q < ANG_LO) begin
			asp_next = ASP_W'(ANG_LO);
		end else begin
			asp_next = ASP_W'(rnd_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_left_q  <= '0;
			prev_right_q <= '0;
			prev_perr_q  <= '0;
			prev_verr_q  <= '0;
			prev_aerr_q  <= '0;
			cmd_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				cmd_valid_q <= 1'b1;
			end else if (cmd.ready) begin
				cmd_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_left_q  <= meas.left_wheel_pos;
						prev_right_q <= meas.right_wheel_pos;
						state_q      <= ST_PERR;
					end
				end
				ST_PERR: state_q <= ST_WPITCH;
				ST_WPITCH: begin
					if (mac_done) begin
						state_q <= ST_LPOS;
					end
				end
				ST_LPOS: begin
					prev_perr_q <= perr_q;
					state_q     <= ST_WPOS;
				end
				ST_WPOS: begin
					if (mac_done) begin
						state_q <= ST_CVSP;
					end
				end
				ST_CVSP: state_q <= ST_VERR;
				ST_VERR: state_q <= ST_LVEL;
				ST_LVEL: begin
					prev_verr_q <= verr_q;
					state_q     <= ST_WVEL;
				end
				ST_WVEL: begin
					if (mac_done) begin
						state_q <= ST_CASP;
					end
				end
				ST_CASP: state_q <= ST_AERR;
				ST_AERR: state_q <= ST_LANG;
				ST_LANG: begin
					prev_aerr_q <= aerr_q;
					state_q     <= ST_WANG;
				end
				ST_WANG: begin
					if (mac_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q   <= pos_sum[POS_W:1];
			vel_q   <= vel_sum[SUM_W-1:1];
			pitch_q <= meas.body_pitch;
		end
		if (state_q == ST_PERR) begin
			perr_q <= sat_sum(perr_sum);
		end
		if ((state_q == ST_WPITCH) && mac_done) begin
			pdeg_q <= pdeg_next;
		end
		if (((state_q == ST_WPOS) || (state_q == ST_WVEL) || (state_q == ST_WANG))
			&& mac_done) begin
			rnd_q <= rnd_next;
		end
		if (state_q == ST_CVSP) begin
			vsp_q <= vsp_next;
		end
		if (state_q == ST_VERR) begin
			verr_q <= sat_sum(verr_sum);
		end
		if (state_q == ST_CASP) begin
			asp_q <= asp_next;
		end
		if (state_q == ST_AERR) begin
			aerr_q <= sat_sum(aerr_sum);
		end
		if (out_load) begin
			torque_q  <= sat_rnd(rnd_q);
			vsp_out_q <= VSP_OUT_W'(vsp_q);
			asp_out_q <= ASP_OUT_W'(asp_q);
		end
	end

	assign cmd.valid             = cmd_valid_q;
	assign cmd.drive_torque      = torque_q;
	assign cmd.velocity_setpoint = vsp_out_q;
	assign cmd.angle_setpoint    = asp_out_q;

endmodule

>>> src/cpbc_checker.sv
`include "cascaded_pd_balance_controller_assert.svh"

module cpbc_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  meas_valid,
	input logic                                  meas_ready,
	input logic                                  cmd_valid,
	input logic                                  cmd_ready,
	input logic signed [cpbc_pkg::TORQUE_W-1:0]  cmd_drive_torque,
	input logic signed [cpbc_pkg::VSP_OUT_W-1:0] cmd_velocity_setpoint,
	input logic signed [cpbc_pkg::ASP_OUT_W-1:0] cmd_angle_setpoint
);
	import cpbc_pkg::*;

	localparam logic signed [ASP_OUT_W-1:0] ANG_MAX = ASP_OUT_W'(10 << FRAC_BITS);

	// one tick in flight: ready drops right after a beat is taken
	`CPBC_ASSERT_NEXT(a_one_tick, meas_valid && meas_ready, !meas_ready,
		"measurement taken while a tick is in progress")

	// a result never shows up the cycle after its measurement
	`CPBC_ASSERT_NEXT(a_no_early_cmd, meas_valid && meas_ready, !$rose(cmd_valid),
		"command appeared too soon after a measurement")

	`CPBC_ASSERT_NEXT(a_cmd_hold, cmd_valid && !cmd_ready,
		cmd_valid && $stable(cmd_drive_torque) && $stable(cmd_velocity_setpoint)
		&& $stable(cmd_angle_setpoint), "stalled command beat changed")

	// angle setpoint stays inside the +/-10 degree clamp
	`CPBC_ASSERT_SAME(a_angle_clamp, cmd_valid && (FRAC_BITS <= 16),
		(cmd_angle_setpoint <= ANG_MAX) && (cmd_angle_setpoint >= -ANG_MAX),
		"angle setpoint outside clamp")

endmodule

bind cascaded_pd_balance_controller cpbc_checker #(
	.FRAC_BITS (FRAC_BITS)
) u_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.meas_valid            (meas.valid),
	.meas_ready            (meas.ready),
	.cmd_valid             (cmd.valid),
	.cmd_ready             (cmd.ready),
	.cmd_drive_torque      (cmd.drive_torque),
	.cmd_velocity_setpoint (cmd.velocity_setpoint),
	.cmd_angle_setpoint    (cmd.angle_setpoint)
);
